[hw/rtl/bfm_pkg.sv]
// Package for the Brenner focus measure block: widths, luma weights,
// register indexes, payload structs and controller command/status structs.
// No dependencies.
`default_nettype none

package bfm_pkg;

    localparam int PIX_W  = 8;
    localparam int ACC_W  = 40;
    localparam int MEAN_W = 32;
    localparam int FRAC_W = 16;
    localparam int SQ_W   = 2 * PIX_W;

    // configuration port
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // BT.601 luma weights, 14 fractional bits, with rounding offset
    localparam int LUMA_SHIFT = 14;
    localparam int LUMA_SUM_W = LUMA_SHIFT + PIX_W;
    localparam logic [LUMA_SHIFT-1:0] LUMA_B = 14'd1868;
    localparam logic [LUMA_SHIFT-1:0] LUMA_G = 14'd9617;
    localparam logic [LUMA_SHIFT-1:0] LUMA_R = 14'd4899;
    localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 22'd8192;

    typedef struct packed {
        logic [PIX_W-1:0] blue_or_gray;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [ACC_W-1:0]  square_sum;
        logic [MEAN_W-1:0] mean_fixed;
    } result_t;

    typedef struct packed {
        logic load_pix;
        logic conv;
        logic sqr;
        logic acc;
        logic div_load;
        logic div_step;
        logic res_write;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/bfm_stream_if.sv]
// Valid/ready stream interface carrying one payload word per handshake.
// Payload type is a parameter; used with bfm_pkg structs.
`default_nettype none

interface bfm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/bfm_ctrl.sv]
// Sequencing controller for the Brenner focus measure.
// Depends on bfm_pkg for the command and status structs.
`default_nettype none

module bfm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_busy,
    input  wire bfm_pkg::status_t status,
    output bfm_pkg::cmd_t        cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sqr    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.frame_end ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_busy)
                begin
                    cmd.res_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bfm_datapath.sv]
// Datapath: gray conversion, row history, squared difference, frame
// accumulator and restoring divider for the mean. Depends on bfm_pkg.
`default_nettype none

module bfm_datapath #(
    parameter int MAX_WIDTH  = bfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfm_pkg::DEF_MAX_HEIGHT,
    parameter int WCNT_W     = $clog2(MAX_WIDTH + 1),
    parameter int HCNT_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bfm_pkg::cmd_t               cmd,
    input  wire bfm_pkg::pixel_t             pix_in,
    input  wire logic                        color_mode,
    input  wire logic [WCNT_W-1:0]           width,
    input  wire logic [HCNT_W-1:0]           height,
    output bfm_pkg::status_t                 status,
    output logic [bfm_pkg::ACC_W-1:0]        sum_out,
    output logic [bfm_pkg::MEAN_W-1:0]       mean_out
);

    localparam int PIX_W   = bfm_pkg::PIX_W;
    localparam int ACC_W   = bfm_pkg::ACC_W;
    localparam int SQ_W    = bfm_pkg::SQ_W;
    localparam int MEAN_W  = bfm_pkg::MEAN_W;
    localparam int DIV_W   = ACC_W + bfm_pkg::FRAC_W;
    localparam int CNT_W   = WCNT_W + HCNT_W;
    localparam int STEP_W  = $clog2(DIV_W);
    localparam int LSUM_W  = bfm_pkg::LUMA_SUM_W;

    bfm_pkg::pixel_t   pix_reg;
    logic [PIX_W-1:0]  gray_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic [PIX_W-1:0]  prev2_reg;
    logic [WCNT_W-1:0] col_reg;
    logic [HCNT_W-1:0] row_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              frame_end_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;

    logic [LSUM_W-1:0] luma_sum;
    logic [PIX_W-1:0]  diff;
    logic [WCNT_W:0]   col_next;
    logic [HCNT_W:0]   row_next;
    logic              row_end;
    logic [ACC_W:0]    acc_sum;
    logic [CNT_W:0]    trial;
    logic              trial_ge;

    assign luma_sum = LSUM_W'(pix_reg.blue_or_gray) * LSUM_W'(bfm_pkg::LUMA_B)
                    + LSUM_W'(pix_reg.green) * LSUM_W'(bfm_pkg::LUMA_G)
                    + LSUM_W'(pix_reg.red) * LSUM_W'(bfm_pkg::LUMA_R)
                    + bfm_pkg::LUMA_ROUND;

    assign diff     = (gray_reg >= prev2_reg) ? (gray_reg - prev2_reg)
                                              : (prev2_reg - gray_reg);
    assign col_next = {1'b0, col_reg} + 1'b1;
    assign row_next = {1'b0, row_reg} + 1'b1;
    assign row_end  = (col_next >= {1'b0, width});

    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(sq_reg);

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, count_reg});

    assign status.frame_end = frame_end_reg;
    assign status.div_last  = (step_reg == STEP_W'(DIV_W - 1));

    assign sum_out  = sum_reg;
    // saturate when the quotient runs past 32 bits
    assign mean_out = (|quo_reg[DIV_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : quo_reg[MEAN_W-1:0];

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            pix_reg <= pix_in;
        end
        if (cmd.conv)
        begin
            gray_reg <= color_mode ? luma_sum[LSUM_W-1:bfm_pkg::LUMA_SHIFT]
                                   : pix_reg.blue_or_gray;
        end
        if (cmd.sqr)
        begin
            sq_reg <= (col_reg >= WCNT_W'(2)) ? SQ_W'(diff) * SQ_W'(diff) : '0;
        end
        if (cmd.div_load)
        begin
            sum_reg   <= acc_reg;
            count_reg <= CNT_W'(width) * CNT_W'(height);
        end
    end

    // row/frame state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            prev2_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            frame_end_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cmd.sqr)
            begin
                frame_end_reg <= 1'b0;
                if (row_end)
                begin
                    col_reg   <= '0;
                    prev_reg  <= '0;
                    prev2_reg <= '0;
                    if (row_next >= {1'b0, height})
                    begin
                        row_reg       <= '0;
                        frame_end_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_next[HCNT_W-1:0];
                    end
                end
                else
                begin
                    col_reg   <= col_next[WCNT_W-1:0];
                    prev_reg  <= gray_reg;
                    prev2_reg <= prev_reg;
                end
            end
            if (cmd.acc)
            begin
                acc_reg <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            end
            else if (cmd.div_load)
            begin
                acc_reg <= '0;
            end
        end
    end

    // restoring divider, one quotient bit per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_load)
        begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= {acc_reg, {bfm_pkg::FRAC_W{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], trial_ge};
        end
    end

endmodule

`default_nettype wire

[hw/rtl/brenner_focus_measure.sv]
// Brenner gradient focus measure; a pixel runs through accept, gray
// conversion, squared difference and accumulate in turn. A frame's last pixel
// adds a load, a 56-step restoring divide and a result write, which waits
// while an earlier word still sits in the output register; the next pixel is
// taken only after that write. Reset (rst_n low, async) clears counters,
// history, accumulator, output valid; 640x480, gray mode.
`default_nettype none

module brenner_focus_measure #(
    parameter int MAX_WIDTH  = bfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bfm_stream_if.sink                       pixel,
    bfm_stream_if.source                     result,
    input  wire logic                        wr_en,
    input  wire logic [bfm_pkg::IDX_W-1:0]   wr_index,
    input  wire logic [bfm_pkg::CFG_W-1:0]   wr_data
);

    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int CFG_W  = bfm_pkg::CFG_W;

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             color_mode_reg;

    // output register: holds a finished word while the sink stalls
    bfm_pkg::result_t result_reg;
    logic             out_valid_reg;

    bfm_pkg::cmd_t    cmd;
    bfm_pkg::status_t status;
    logic [WCNT_W-1:0] width_clamped;
    logic [HCNT_W-1:0] height_clamped;
    logic [bfm_pkg::ACC_W-1:0]  sum_out;
    logic [bfm_pkg::MEAN_W-1:0] mean_out;

    // zero counts as one, anything past the maximum as the maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            width_clamped = WCNT_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            width_clamped = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = WCNT_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            height_clamped = HCNT_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            height_clamped = HCNT_W'(MAX_HEIGHT);
        end
        else
        begin
            height_clamped = HCNT_W'(height_reg);
        end
    end

    // register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= bfm_pkg::RESET_WIDTH;
            height_reg     <= bfm_pkg::RESET_HEIGHT;
            color_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bfm_pkg::REG_FRAME_WIDTH:  width_reg      <= wr_data;
                bfm_pkg::REG_FRAME_HEIGHT: height_reg     <= wr_data;
                bfm_pkg::REG_COLOR_MODE:   color_mode_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    bfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .out_busy (out_valid_reg),
        .status   (status),
        .cmd      (cmd)
    );

    bfm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WCNT_W     (WCNT_W),
        .HCNT_W     (HCNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pix_in     (pixel.payload),
        .color_mode (color_mode_reg),
        .width      (width_clamped),
        .height     (height_clamped),
        .status     (status),
        .sum_out    (sum_out),
        .mean_out   (mean_out)
    );

    // load the result word; drop the valid once the sink takes it
    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            result_reg.square_sum <= sum_out;
            result_reg.mean_fixed <= mean_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = result_reg;

    // a result is never written over one that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_write |-> !out_valid_reg)
        else $error("result written while output register full");

    // one pixel in flight at a time
    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> !pixel.ready)
        else $error("pixel accepted while previous pixel busy");

    // output valid rises only from a result write
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.res_write))
        else $error("output valid without result write");

endmodule

`default_nettype wire

[tb/tb_brenner_focus_measure.sv]
`timescale 1ns / 100ps
// Self-checking testbench for brenner_focus_measure: streams pixel words, predicts
// each frame's gradient sum and 16.16 mean, and compares every result word.
// Depends on bfm_pkg and bfm_stream_if from the RTL.

module tb_brenner_focus_measure;

    typedef bfm_pkg::pixel_t  pixel_t;
    typedef bfm_pkg::result_t result_t;

    localparam int PIX_W      = bfm_pkg::PIX_W;
    localparam int ACC_W      = bfm_pkg::ACC_W;
    localparam int MEAN_W     = bfm_pkg::MEAN_W;
    localparam int FRAC_W     = bfm_pkg::FRAC_W;
    localparam int IDX_W      = bfm_pkg::IDX_W;
    localparam int CFG_W      = bfm_pkg::CFG_W;
    localparam int LUMA_SHIFT = bfm_pkg::LUMA_SHIFT;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    // Covers the wait from a frame's last pixel to its word, plus the pixel pipe.
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PIXELS = 1390;
    localparam int LONG_RUN      = 64;
    localparam int RUN_LIMIT_NS  = 40_000_000;
    localparam int unsigned MAX_W = bfm_pkg::DEF_MAX_WIDTH;
    localparam int unsigned MAX_H = bfm_pkg::DEF_MAX_HEIGHT;

    localparam logic [IDX_W-1:0]  REG_UNUSED     = 2'd3;
    localparam logic [CFG_W-1:0]  SIZE_FIELD_MAX = '1;
    localparam logic [ACC_W-1:0]  SUM_LIMIT      = '1;
    localparam logic [MEAN_W-1:0] MEAN_LIMIT     = '1;

    typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_DARK} texture_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    bfm_stream_if #(.payload_t(pixel_t))  pixel_ch ();
    bfm_stream_if #(.payload_t(result_t)) result_ch ();

    brenner_focus_measure dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Pixel words waiting to be driven, and frame results waiting to arrive.
    pixel_t  pending_pixels[$];
    result_t frame_results[$];

    // Shadow of the block's registers and of its per-row / per-frame state.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             color_reg;
    logic [PIX_W-1:0] gray_d1;
    logic [PIX_W-1:0] gray_d2;
    logic [CFG_W-1:0] col_count;
    logic [CFG_W-1:0] row_count;
    logic [ACC_W-1:0] grad_sum;

    int error_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Zero reads as one, anything above the maximum reads as the maximum.
    function automatic int unsigned effective_size(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == 0)
            return 1;
        if (32'(v) > limit)
            return limit;
        return 32'(v);
    endfunction

    // BT.601 luma with 14 fractional bits and round-half-up.
    function automatic logic [PIX_W-1:0] luma(pixel_t px);
        logic [31:0] weighted;
        weighted = bfm_pkg::LUMA_B * px.blue_or_gray + bfm_pkg::LUMA_G * px.green
                 + bfm_pkg::LUMA_R * px.red + bfm_pkg::LUMA_ROUND;
        return weighted[LUMA_SHIFT +: PIX_W];
    endfunction

    function automatic void mirror_reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            bfm_pkg::REG_FRAME_WIDTH:  width_reg  = data;
            bfm_pkg::REG_FRAME_HEIGHT: height_reg = data;
            bfm_pkg::REG_COLOR_MODE:   color_reg  = data[0];
            default: ;
        endcase
    endfunction

    // Advance the shadow state by one accepted pixel; queue a frame result at
    // the last pixel of a frame.
    function automatic void accumulate_pixel(pixel_t px);
        int unsigned              w;
        int unsigned              h;
        logic [PIX_W-1:0]         gray;
        logic [PIX_W-1:0]         diff;
        logic [ACC_W:0]           sum_next;
        logic [ACC_W+FRAC_W-1:0]  mean_full;
        result_t                  res;
        w = effective_size(width_reg, MAX_W);
        h = effective_size(height_reg, MAX_H);
        gray = color_reg ? luma(px) : px.blue_or_gray;
        if (col_count >= 2)
        begin
            diff = (gray >= gray_d2) ? gray - gray_d2 : gray_d2 - gray;
            sum_next = grad_sum + diff * diff;
            grad_sum = sum_next[ACC_W] ? SUM_LIMIT : sum_next[ACC_W-1:0];
        end
        gray_d2 = gray_d1;
        gray_d1 = gray;
        col_count = col_count + 1'b1;
        if (col_count < w)
            return;
        // end of row: drop the history so the next row starts clean
        col_count = '0;
        gray_d1 = '0;
        gray_d2 = '0;
        row_count = row_count + 1'b1;
        if (row_count < h)
            return;
        row_count = '0;
        mean_full = {grad_sum, {FRAC_W{1'b0}}} / (w * h);
        res.square_sum = grad_sum;
        res.mean_fixed = (mean_full > MEAN_LIMIT) ? MEAN_LIMIT : mean_full[MEAN_W-1:0];
        frame_results.push_back(res);
        grad_sum = '0;
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (frame_results.size() == 0)
        begin
            $error("result word with nothing expected: square_sum %0d, mean_fixed %0d",
                   got.square_sum, got.mean_fixed);
            error_count++;
            return;
        end
        want = frame_results.pop_front();
        if (got.square_sum !== want.square_sum)
        begin
            $error("square_sum: expected %0d, actual %0d", want.square_sum, got.square_sum);
            error_count++;
        end
        if (got.mean_fixed !== want.mean_fixed)
        begin
            $error("mean_fixed: expected %0d, actual %0d", want.mean_fixed, got.mean_fixed);
            error_count++;
        end
    endfunction

    // Pixel driver: hold a word until it is taken, then pop the next one after
    // a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid   <= 1'b0;
            pixel_ch.payload <= '0;
            gap_left = 0;
        end
        else if (!pixel_ch.valid || pixel_ch.ready)
        begin
            if (gap_left > 0)
            begin
                pixel_ch.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_pixels.size() > 0)
            begin
                pixel_ch.valid   <= 1'b1;
                pixel_ch.payload <= pending_pixels.pop_front();
                gap_left = sender_steady ? 0 : pick_gap();
            end
            else
            begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: mirror register writes, predict on accepted pixels, check
    // accepted results, and apply random backpressure on the result side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = bfm_pkg::RESET_WIDTH;
            height_reg = bfm_pkg::RESET_HEIGHT;
            color_reg  = 1'b0;
            gray_d1    = '0;
            gray_d2    = '0;
            col_count  = '0;
            row_count  = '0;
            grad_sum   = '0;
            stall_left = 0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (wr_en)
                mirror_reg_write(wr_index, wr_data);
            // check before predicting so a result never meets its own frame
            if (result_ch.valid && result_ch.ready)
                check_result(result_ch.payload);
            if (pixel_ch.valid && pixel_ch.ready)
                accumulate_pixel(pixel_ch.payload);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!receiver_steady && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // Wait until every queued pixel is taken and every frame result has come,
    // then let the divider run out before touching the registers.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_ch.valid || frame_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic pixel_t gray_pixel(logic [PIX_W-1:0] v);
        pixel_t px;
        px.blue_or_gray = v;
        px.green        = $urandom_range(0, 255);
        px.red          = $urandom_range(0, 255);
        return px;
    endfunction

    function automatic pixel_t make_pixel(texture_t tex);
        pixel_t px;
        case (tex)
            TEXTURE_BINARY:
            begin
                px.blue_or_gray = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green        = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.red          = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            TEXTURE_DARK:
            begin
                px.blue_or_gray = $urandom_range(0, 15);
                px.green        = $urandom_range(0, 15);
                px.red          = $urandom_range(0, 15);
            end
            default:
            begin
                px.blue_or_gray = $urandom_range(0, 255);
                px.green        = $urandom_range(0, 255);
                px.red          = $urandom_range(0, 255);
            end
        endcase
        return px;
    endfunction

    task automatic queue_pixels(int unsigned count, texture_t tex);
        repeat (count) pending_pixels.push_back(make_pixel(tex));
    endtask

    // Stopwatch: a hung handshake ends the run here.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned frame_px;
        int unsigned batch;
        int unsigned random_sent;
        texture_t    tex;

        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = '0;
        wr_data          = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings (640 wide, gray): a partial row, then shrink the width
        // under it so the row and the one-row frame close on the next pixel.
        pending_pixels.push_back(gray_pixel(8'h00));
        pending_pixels.push_back(gray_pixel(8'hFF));
        pending_pixels.push_back(gray_pixel(8'hFF));
        pending_pixels.push_back(gray_pixel(8'h00));
        pending_pixels.push_back(gray_pixel(8'h80));
        wait_idle();
        write_reg(bfm_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd1);
        @(negedge clk);
        pending_pixels.push_back(gray_pixel(8'h7F));
        wait_idle();

        // Zero sizes behave as one: every pixel is a whole frame.
        write_reg(bfm_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd0);
        @(negedge clk);
        pending_pixels.push_back(gray_pixel(8'hFF));
        pending_pixels.push_back(gray_pixel(8'h00));
        wait_idle();

        // Two-wide rows never reach column two: sum stays zero.
        write_reg(bfm_pkg::REG_FRAME_WIDTH, 13'd2);
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd2);
        @(negedge clk);
        pending_pixels.push_back(gray_pixel(8'h00));
        pending_pixels.push_back(gray_pixel(8'hFF));
        pending_pixels.push_back(gray_pixel(8'hFF));
        pending_pixels.push_back(gray_pixel(8'h00));
        wait_idle();

        // Color corners: white, black, and each primary alone.
        write_reg(bfm_pkg::REG_FRAME_WIDTH, 13'd3);
        write_reg(bfm_pkg::REG_COLOR_MODE, 13'd1);
        @(negedge clk);
        pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
        pending_pixels.push_back('{8'h00, 8'h00, 8'h00});
        pending_pixels.push_back('{8'h00, 8'h00, 8'h00});
        pending_pixels.push_back('{8'hFF, 8'h00, 8'h00});
        pending_pixels.push_back('{8'h00, 8'hFF, 8'h00});
        pending_pixels.push_back('{8'h00, 8'h00, 8'hFF});
        wait_idle();

        // A write to the unused index must leave the 3x2 color setting alone.
        write_reg(REG_UNUSED, SIZE_FIELD_MAX);
        @(negedge clk);
        queue_pixels(6, TEXTURE_BINARY);
        wait_idle();

        // Shrink the height after two rows of a 3x3 frame: it ends with the
        // next row.
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd3);
        write_reg(bfm_pkg::REG_COLOR_MODE, 13'd0);
        @(negedge clk);
        queue_pixels(6, TEXTURE_NOISE);
        wait_idle();
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd1);
        @(negedge clk);
        queue_pixels(3, TEXTURE_NOISE);
        wait_idle();

        // Widest setting: the all-ones width field clamps to the maximum, so a
        // long 0,0,255,255 run stays in one row; closing the width then ends
        // the row and the one-row frame on the next pixel.
        write_reg(bfm_pkg::REG_FRAME_WIDTH, SIZE_FIELD_MAX);
        @(negedge clk);
        sender_steady = 1'b1;
        for (int i = 0; i < LONG_RUN; i++)
            pending_pixels.push_back(gray_pixel((i % 4) < 2 ? 8'h00 : 8'hFF));
        wait_idle();
        write_reg(bfm_pkg::REG_FRAME_WIDTH, 13'd1);
        @(negedge clk);
        pending_pixels.push_back(gray_pixel(8'h00));
        wait_idle();

        // Tallest setting: one column, height field all ones, color input;
        // closing the height ends the frame on the next pixel.
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, SIZE_FIELD_MAX);
        write_reg(bfm_pkg::REG_COLOR_MODE, 13'd1);
        @(negedge clk);
        queue_pixels(LONG_RUN, TEXTURE_NOISE);
        wait_idle();
        write_reg(bfm_pkg::REG_FRAME_HEIGHT, 13'd1);
        @(negedge clk);
        queue_pixels(1, TEXTURE_NOISE);
        wait_idle();
        sender_steady = 1'b0;

        // Random part: small frames under changing settings, whole frames most
        // of the time, with broken tails that carry into the next setting.
        cur_w = 1;
        cur_h = 1;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    cur_w = $urandom_range(13, 48);
                else
                    cur_w = $urandom_range(0, 12);
                write_reg(bfm_pkg::REG_FRAME_WIDTH, CFG_W'(cur_w));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    cur_h = $urandom_range(5, 12);
                else
                    cur_h = $urandom_range(0, 4);
                write_reg(bfm_pkg::REG_FRAME_HEIGHT, CFG_W'(cur_h));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(bfm_pkg::REG_COLOR_MODE,
                          CFG_W'($urandom_range(0, SIZE_FIELD_MAX)));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom_range(0, SIZE_FIELD_MAX)));
            sender_steady   = ($urandom_range(0, 4) == 0);
            receiver_steady = ($urandom_range(0, 4) == 0);
            frame_px = effective_size(CFG_W'(cur_w), MAX_W)
                     * effective_size(CFG_W'(cur_h), MAX_H);
            @(negedge clk);

            if ($urandom_range(0, 7) == 0)
            begin
                // noise: a run of pixels with no regard to frame bounds
                batch = $urandom_range(1, 10);
                queue_pixels(batch, TEXTURE_NOISE);
            end
            else
            begin
                batch = 0;
                repeat ($urandom_range(1, 4))
                begin
                    tex = texture_t'($urandom_range(0, 2));
                    queue_pixels(frame_px, tex);
                    batch += frame_px;
                end
                // broken frame: stop partway, the next setting picks it up
                if (frame_px > 1 && $urandom_range(0, 3) == 0)
                begin
                    frame_px = $urandom_range(1, frame_px - 1);
                    queue_pixels(frame_px, TEXTURE_NOISE);
                    batch += frame_px;
                end
            end
            random_sent += batch;
            wait_idle();
        end

        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        wait_idle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bfm_pkg.sv
hw/rtl/bfm_stream_if.sv
hw/rtl/bfm_ctrl.sv
hw/rtl/bfm_datapath.sv
hw/rtl/brenner_focus_measure.sv
tb/tb_brenner_focus_measure.sv
